// ===== src/espd_pkg.sv =====
// Shared constants, codes and control types of the encoder speed PID drive.
package espd_pkg;

   // Encoder changes between two speed measurements.
   localparam logic [7:0] CHANGES_PER_UPDATE = 8'd192;

   // Speed scaling: Q15.8 speed = delta * SPEED_NUM / (SPEED_DEN * dt).
   localparam logic [28:0] SPEED_NUM = 29'd482548224;
   localparam logic [17:0] SPEED_DEN = 18'd224900;
   localparam int          NUM_W     = 60;
   localparam int          DEN_W     = 50;
   localparam logic [5:0]  DIV_LAST  = 6'(NUM_W - 1);

   localparam logic signed [23:0] SPEED_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] SPEED_MIN = 24'sh800000;

   // Drive limits, integer part of Q8.8.
   localparam logic [7:0] DRIVE_MAX   = 8'd255;
   localparam logic [7:0] DRIVE_MIN   = 8'd30;
   localparam logic [7:0] DRIVE_STALL = 8'd100;
   localparam logic signed [45:0] ACC_HI = $signed({14'd0, DRIVE_MAX, 24'd0});
   localparam logic signed [45:0] ACC_LO = $signed({14'd0, DRIVE_MIN, 24'd0});

   // Control modes; any other code brakes.
   localparam logic [1:0] MODE_MANUAL = 2'd0;
   localparam logic [1:0] MODE_SPEED  = 2'd1;
   localparam logic [1:0] MODE_BRAKE  = 2'd2;
   localparam logic [1:0] MODE_SPARE  = 2'd3;

   // Register indexes.
   localparam logic [2:0] REG_CONTROL_MODE   = 3'd0;
   localparam logic [2:0] REG_TARGET_SPEED   = 3'd1;
   localparam logic [2:0] REG_MANUAL_DRIVE   = 3'd2;
   localparam logic [2:0] REG_MANUAL_REVERSE = 3'd3;
   localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd4;
   localparam logic [2:0] REG_GAIN_P         = 3'd5;
   localparam logic [2:0] REG_GAIN_I         = 3'd6;
   localparam logic [2:0] REG_GAIN_D         = 3'd7;

   typedef enum logic [3:0] {
      S_IDLE, S_EVAL, S_SPD_DIV, S_SPD_WR, S_MODE,
      S_PID_E, S_PID_P, S_PID_I, S_PID_D, S_PID_CLAMP, S_OUT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic eval;
      logic div_start;
      logic spd_wr;
      logic mode_step;
      logic pid_e;
      logic pid_p;
      logic pid_i;
      logic pid_d;
      logic pid_clamp;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic need_speed;
      logic div_done;
      logic pid_go;
   } sts_type;

endpackage

// ===== src/espd_div.sv =====
// Restoring divider, one quotient bit a cycle, saturating quotient flag.
module espd_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [espd_pkg::NUM_W-1:0]  num,
   input  logic [espd_pkg::DEN_W-1:0]  den,
   output logic                        done,
   output logic [23:0]                 quot,
   output logic                        big
);
   import espd_pkg::*;

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [23:0]      q_ff, q_in;
   logic             ovf_ff, ovf_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic             ge;

   // One shift-subtract step
   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         q_in    = '0;
         ovf_in  = 1'b0;
         cnt_in  = DIV_LAST;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         rem_in = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         q_in   = {q_ff[22:0], ge};
         ovf_in = ovf_ff | q_ff[23];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign big  = ovf_ff | q_ff[23];
endmodule

// ===== src/espd_dp.sv =====
// Datapath: registers, speed measurement, PID arithmetic and result register.
module espd_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  espd_pkg::cmd_type      cmd,
   output espd_pkg::sts_type      sts,
   input  logic                   csr_valid,
   input  logic [2:0]             csr_index,
   input  logic [23:0]            csr_wdata,
   input  logic [31:0]            req_time_ms,
   input  logic signed [31:0]     req_encoder_position,
   output logic [7:0]             rsp_drive_level,
   output logic                   rsp_reverse,
   output logic                   rsp_brake,
   output logic                   rsp_speed_updated,
   output logic signed [23:0]     rsp_measured_speed,
   output logic                   rsp_is_stopped
);
   import espd_pkg::*;

   // Configuration
   logic [1:0]         mode_ff;
   logic signed [23:0] target_ff;
   logic [7:0]         man_drive_ff;
   logic               man_rev_ff;
   logic [15:0]        period_ff, gp_ff, gi_ff, gd_ff;

   // Block state
   logic [31:0]        last_pos_ff, last_pos_in;
   logic [7:0]         count_ff, count_in;
   logic [31:0]        lct_ff, lct_in, smt_ff, smt_in, smp_ff, smp_in, pmt_ff, pmt_in;
   logic signed [23:0] speed_ff, speed_in, prev_ff, prev_in;
   logic [15:0]        accum_ff, accum_in;
   logic               stall_ff, stall_in, upd_ff, upd_in;

   // Work registers
   logic [31:0]        t_ff, pos_ff;
   logic signed [23:0] e_ff, e_in;
   logic signed [45:0] acc_ff, acc_in;

   // Result register
   logic [7:0]         o_drive_ff;
   logic               o_rev_ff, o_brk_ff, o_upd_ff, o_stop_ff;
   logic signed [23:0] o_speed_ff;

   logic               changed, hit, stall_cond, pid_due, neg, dv_done, dv_big;
   logic [7:0]         cnt_inc;
   logic [31:0]        since, delta, mag, dt;
   logic [35:0]        since10;
   logic [19:0]        period11;
   logic [23:0]        dv_quot;
   logic signed [23:0] spd_res;
   logic signed [24:0] diff25, ediff;
   logic signed [25:0] e26;
   logic signed [40:0] prod_p, prod_i;
   logic signed [41:0] prod_d;
   logic [15:0]        clamp16;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_BRAKE;
         target_ff    <= '0;
         man_drive_ff <= '0;
         man_rev_ff   <= 1'b0;
         period_ff    <= 16'd50;
         gp_ff        <= 16'd4588;
         gi_ff        <= 16'd1638;
         gd_ff        <= 16'd5243;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CONTROL_MODE:   mode_ff      <= csr_wdata[1:0];
            REG_TARGET_SPEED:   target_ff    <= $signed(csr_wdata);
            REG_MANUAL_DRIVE:   man_drive_ff <= csr_wdata[7:0];
            REG_MANUAL_REVERSE: man_rev_ff   <= csr_wdata[0];
            REG_SAMPLE_PERIOD:  period_ff    <= csr_wdata[15:0];
            REG_GAIN_P:         gp_ff        <= csr_wdata[15:0];
            REG_GAIN_I:         gi_ff        <= csr_wdata[15:0];
            REG_GAIN_D:         gd_ff        <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Change, stall and timing tests
   always_comb begin
      changed    = pos_ff != last_pos_ff;
      cnt_inc    = count_ff + 8'd1;
      hit        = cnt_inc >= CHANGES_PER_UPDATE;
      since      = t_ff - lct_ff;
      since10    = ({4'd0, since} << 3) + ({4'd0, since} << 1);
      period11   = ({4'd0, period_ff} << 3) + ({4'd0, period_ff} << 1) + {4'd0, period_ff};
      stall_cond = since10 > {16'd0, period11};
      pid_due    = (t_ff - pmt_ff) > {16'd0, period_ff};
      delta      = pos_ff - smp_ff;
      neg        = delta[31];
      mag        = neg ? 32'd0 - delta : delta;
      dt         = t_ff - smt_ff;
   end

   assign sts.need_speed = changed && hit;
   assign sts.div_done   = dv_done;
   assign sts.pid_go     = (mode_ff == MODE_SPEED) && pid_due && (target_ff != '0);

   espd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (NUM_W'(mag) * NUM_W'(SPEED_NUM)),
      .den   (DEN_W'(dt) * DEN_W'(SPEED_DEN)),
      .done  (dv_done),
      .quot  (dv_quot),
      .big   (dv_big)
   );

   // Signed, saturated speed from the quotient
   always_comb begin
      if (mag == '0)      spd_res = '0;
      else if (dt == '0)  spd_res = neg ? SPEED_MIN : SPEED_MAX;
      else if (neg)       spd_res = dv_big ? SPEED_MIN : $signed(24'(25'd0 - {1'b0, dv_quot}));
      else                spd_res = dv_big ? SPEED_MAX : $signed(dv_quot);
   end

   // PID arithmetic
   always_comb begin
      diff25 = {target_ff[23], target_ff} - {speed_ff[23], speed_ff};
      e26    = target_ff[23] ? 26'sd0 - {diff25[24], diff25} : {diff25[24], diff25};
      ediff  = {e_ff[23], e_ff} - {prev_ff[23], prev_ff};
      prod_p = $signed({1'b0, gp_ff}) * e_ff;
      prod_i = $signed({1'b0, gi_ff}) * prev_ff;
      prod_d = $signed({1'b0, gd_ff}) * ediff;
      if (stall_ff)              clamp16 = {DRIVE_STALL, 8'd0};
      else if (acc_ff > ACC_HI)  clamp16 = {DRIVE_MAX, 8'd0};
      else if (acc_ff < ACC_LO)  clamp16 = {DRIVE_MIN, 8'd0};
      else                       clamp16 = acc_ff[31:16];
   end

   // Next state of the block
   always_comb begin
      last_pos_in = last_pos_ff;
      count_in    = count_ff;
      lct_in      = lct_ff;
      smt_in      = smt_ff;
      smp_in      = smp_ff;
      pmt_in      = pmt_ff;
      speed_in    = speed_ff;
      prev_in     = prev_ff;
      accum_in    = accum_ff;
      stall_in    = stall_ff;
      upd_in      = upd_ff;
      e_in        = e_ff;
      acc_in      = acc_ff;
      if (cmd.load_req) upd_in = 1'b0;
      if (cmd.eval) begin
         if (changed) begin
            stall_in    = 1'b0;
            lct_in      = t_ff;
            last_pos_in = pos_ff;
            count_in    = hit ? 8'd0 : cnt_inc;
         end else if (stall_cond) begin
            speed_in = '0;
            stall_in = 1'b1;
            upd_in   = 1'b1;
         end
      end
      if (cmd.spd_wr) begin
         speed_in = spd_res;
         smt_in   = t_ff;
         smp_in   = pos_ff;
         upd_in   = 1'b1;
      end
      if (cmd.mode_step) begin
         if (mode_ff == MODE_SPEED) begin
            if (pid_due) pmt_in = t_ff;
         end else if (mode_ff == MODE_MANUAL) begin
            accum_in = {man_drive_ff, 8'd0};
         end else begin
            accum_in = '0;
         end
      end
      if (cmd.pid_e) begin
         if (e26 > 26'sd8388607)       e_in = SPEED_MAX;
         else if (e26 < -26'sd8388608) e_in = SPEED_MIN;
         else                          e_in = e26[23:0];
      end
      if (cmd.pid_p) acc_in = $signed({14'd0, accum_ff, 16'd0}) + {{5{prod_p[40]}}, prod_p};
      if (cmd.pid_i) acc_in = acc_ff + {{5{prod_i[40]}}, prod_i};
      if (cmd.pid_d) acc_in = acc_ff + {{4{prod_d[41]}}, prod_d};
      if (cmd.pid_clamp) begin
         accum_in = clamp16;
         prev_in  = e_ff;
      end
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff <= '0;
         count_ff    <= '0;
         lct_ff      <= '0;
         smt_ff      <= '0;
         smp_ff      <= '0;
         pmt_ff      <= '0;
         speed_ff    <= '0;
         prev_ff     <= '0;
         accum_ff    <= '0;
         stall_ff    <= 1'b1;
         upd_ff      <= 1'b0;
      end else begin
         last_pos_ff <= last_pos_in;
         count_ff    <= count_in;
         lct_ff      <= lct_in;
         smt_ff      <= smt_in;
         smp_ff      <= smp_in;
         pmt_ff      <= pmt_in;
         speed_ff    <= speed_in;
         prev_ff     <= prev_in;
         accum_ff    <= accum_in;
         stall_ff    <= stall_in;
         upd_ff      <= upd_in;
      end
   end

   // Capture the request and work values
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         t_ff   <= req_time_ms;
         pos_ff <= req_encoder_position;
      end
      e_ff   <= e_in;
      acc_ff <= acc_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         o_drive_ff <= accum_ff[15:8];
         o_rev_ff   <= (mode_ff == MODE_SPEED) ? target_ff[23] :
                       (mode_ff == MODE_MANUAL) ? man_rev_ff : 1'b0;
         o_brk_ff   <= (mode_ff != MODE_SPEED) && (mode_ff != MODE_MANUAL);
         o_upd_ff   <= upd_ff;
         o_speed_ff <= speed_ff;
         o_stop_ff  <= stall_ff;
      end
   end

   assign rsp_drive_level    = o_drive_ff;
   assign rsp_reverse        = o_rev_ff;
   assign rsp_brake          = o_brk_ff;
   assign rsp_speed_updated  = o_upd_ff;
   assign rsp_measured_speed = o_speed_ff;
   assign rsp_is_stopped     = o_stop_ff;
endmodule

// ===== src/espd_ctrl.sv =====
// Controller: sequences one request through the datapath and owns the request and result handshakes.
module espd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  espd_pkg::sts_type sts,
   output espd_pkg::cmd_type cmd
);
   import espd_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.need_speed) begin
               cmd.div_start = 1'b1;
               state_in      = S_SPD_DIV;
            end else begin
               state_in = S_MODE;
            end
         end
         S_SPD_DIV:   if (sts.div_done) state_in = S_SPD_WR;
         S_SPD_WR: begin
            cmd.spd_wr = 1'b1;
            state_in   = S_MODE;
         end
         S_MODE: begin
            cmd.mode_step = 1'b1;
            state_in      = sts.pid_go ? S_PID_E : S_OUT;
         end
         S_PID_E: begin
            cmd.pid_e = 1'b1;
            state_in  = S_PID_P;
         end
         S_PID_P: begin
            cmd.pid_p = 1'b1;
            state_in  = S_PID_I;
         end
         S_PID_I: begin
            cmd.pid_i = 1'b1;
            state_in  = S_PID_D;
         end
         S_PID_D: begin
            cmd.pid_d = 1'b1;
            state_in  = S_PID_CLAMP;
         end
         S_PID_CLAMP: begin
            cmd.pid_clamp = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.out_load)  rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else               rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> state_ff == S_EVAL)
      else $error("accepted request did not enter evaluation");
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> state_ff == S_SPD_DIV)
      else $error("divider finished outside the speed state");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");
`endif
endmodule

// ===== src/encoder_speed_pid_drive.sv =====
// Top level of the encoder speed meter with incremental PID motor drive.
//
//   channel  | handshake             | payload
//   req      | req_valid / req_ready | req_time_ms, req_encoder_position
//   rsp      | rsp_valid / rsp_ready | drive, direction, brake, speed, status
//   csr      | csr_valid / csr_ready | csr_index, csr_wdata
//
// A request passes evaluation, the mode step and output; a PID run adds its error,
// P, I, D and clamp steps, and a speed measurement adds the bit-serial divider.
// Synchronous reset restores configuration and state, not work or result registers.
// The next request is taken while the previous result waits in the output register.
// Configuration writes are always taken.
module encoder_speed_pid_drive (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_time_ms,
   input  logic signed [31:0] req_encoder_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_drive_level,
   output logic               rsp_reverse,
   output logic               rsp_brake,
   output logic               rsp_speed_updated,
   output logic signed [23:0] rsp_measured_speed,
   output logic               rsp_is_stopped,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);
   import espd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   espd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   espd_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .csr_valid            (csr_valid),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_time_ms          (req_time_ms),
      .req_encoder_position (req_encoder_position),
      .rsp_drive_level      (rsp_drive_level),
      .rsp_reverse          (rsp_reverse),
      .rsp_brake            (rsp_brake),
      .rsp_speed_updated    (rsp_speed_updated),
      .rsp_measured_speed   (rsp_measured_speed),
      .rsp_is_stopped       (rsp_is_stopped)
   );
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the encoder speed PID drive.
`timescale 1ns / 100ps

module testbench;
   import espd_pkg::*;

   logic               clock, reset;
   logic               req_valid, req_ready;
   logic [31:0]        req_time_ms;
   logic signed [31:0] req_encoder_position;
   logic               rsp_valid, rsp_ready;
   logic [7:0]         rsp_drive_level;
   logic               rsp_reverse, rsp_brake, rsp_speed_updated, rsp_is_stopped;
   logic signed [23:0] rsp_measured_speed;
   logic               csr_valid, csr_ready;
   logic [2:0]         csr_index;
   logic [23:0]        csr_wdata;

   encoder_speed_pid_drive dut (.*);

   typedef struct packed {
      logic [7:0]         drive;
      logic               rev;
      logic               brk;
      logic               upd;
      logic signed [23:0] speed;
      logic               stopped;
   } drive_result_type;

   // predictor copy of the registers
   logic [1:0]         m_mode;
   logic signed [23:0] m_target;
   logic [7:0]         m_manual;
   logic               m_manual_rev;
   logic [15:0]        m_period, m_gp, m_gi, m_gd;
   // predictor copy of the state
   logic signed [31:0] m_last_pos, m_mark_pos;
   logic [7:0]         m_changes;
   logic [31:0]        m_change_t, m_mark_t, m_pid_t, m_t_now;
   logic signed [23:0] m_speed, m_prev_err;
   logic [15:0]        m_accum;
   logic               m_stall;

   drive_result_type expected_drive[$];
   int  failures = 0;
   int  idle_cycles = 0;
   bit  allow_idle = 1;
   bit  rx_hold = 0;
   int  hold_count = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic logic signed [23:0] sat24(longint v);
      if (v > 64'sd8388607) return SPEED_MAX;
      if (v < -64'sd8388608) return SPEED_MIN;
      return v[23:0];
   endfunction

   function automatic logic signed [23:0] speed_from_counts(logic signed [31:0] pos,
                                                            logic [31:0] t);
      logic [31:0] du, el;
      longint      delta, q;
      longint unsigned mag, dt;
      du = pos - m_mark_pos;
      el = t - m_mark_t;
      delta = longint'($signed(du));
      dt = el;
      mag = delta < 0 ? -delta : delta;
      if (mag == 0) return 0;
      if (dt == 0) return delta < 0 ? SPEED_MIN : SPEED_MAX;
      q = (mag * 64'd482548224) / (64'd224900 * dt);
      if (q > 64'd8388608) q = 64'd8388608;
      return sat24(delta < 0 ? -q : q);
   endfunction

   task automatic model_pid();
      longint e, v;
      if (m_target == 0) return;
      e = longint'(m_target) - longint'(m_speed);
      if (m_target < 0) e = -e;
      e = sat24(e);
      v = longint'(m_accum) * 65536 + longint'(m_gp) * e
          + longint'(m_gi) * longint'(m_prev_err)
          + longint'(m_gd) * (e - longint'(m_prev_err));
      if (v > (longint'(255) <<< 24)) v = longint'(255) <<< 24;
      if (v < (longint'(30) <<< 24)) v = longint'(30) <<< 24;
      if (m_stall) v = longint'(100) <<< 24;
      m_accum = v[31:16];
      m_prev_err = e[23:0];
   endtask

   task automatic model_drive_step(logic [31:0] t, logic signed [31:0] pos);
      drive_result_type r;
      logic [31:0]      since;
      r = '0;
      since = t - m_change_t;
      if (pos != m_last_pos) begin
         m_stall = 0;
         m_change_t = t;
         m_last_pos = pos;
         m_changes++;
         if (m_changes >= CHANGES_PER_UPDATE) begin
            m_changes = 0;
            m_speed = speed_from_counts(pos, t);
            m_mark_t = t;
            m_mark_pos = pos;
            r.upd = 1;
         end
      end else if (64'(since) * 10 > 64'(m_period) * 11) begin
         m_speed = 0;
         m_stall = 1;
         r.upd = 1;
      end
      if (m_mode == MODE_SPEED) begin
         if ((t - m_pid_t) > 32'(m_period)) begin
            model_pid();
            m_pid_t = t;
         end
         r.rev = m_target < 0;
      end else if (m_mode == MODE_MANUAL) begin
         m_accum = {m_manual, 8'd0};
         r.rev = m_manual_rev;
      end else begin
         m_accum = 0;
         r.brk = 1;
      end
      r.drive = m_accum[15:8];
      r.speed = m_speed;
      r.stopped = m_stall;
      expected_drive.push_back(r);
   endtask

   // Drop valid for a random gap
   task automatic random_gap();
      int n;
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 15);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Send one request and predict its result
   task automatic send_poll(logic [31:0] t, logic signed [31:0] pos);
      random_gap();
      req_valid <= 1;
      req_time_ms <= t;
      req_encoder_position <= pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model_drive_step(t, pos);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (expected_drive.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (idx)
         REG_CONTROL_MODE:   m_mode = val[1:0];
         REG_TARGET_SPEED:   m_target = val;
         REG_MANUAL_DRIVE:   m_manual = val[7:0];
         REG_MANUAL_REVERSE: m_manual_rev = val[0];
         REG_SAMPLE_PERIOD:  m_period = val[15:0];
         REG_GAIN_P:         m_gp = val[15:0];
         REG_GAIN_I:         m_gi = val[15:0];
         default:            m_gd = val[15:0];
      endcase
      @(posedge clock);
   endtask

   // Advance time and move the encoder, mostly by small steps
   task automatic run_motion(int n, int max_step, int max_dt);
      logic signed [31:0] p;
      for (int i = 0; i < n; i++) begin
         p = m_last_pos;
         if ($urandom_range(0, 19) == 0) p = $urandom;
         else if ($urandom_range(0, 4) != 0)
            p = p + $signed($urandom_range(0, 2 * max_step)) - max_step;
         m_t_now = m_t_now + $urandom_range(0, max_dt);
         send_poll(m_t_now, p);
      end
   endtask

   task automatic test_directed();
      send_poll(32'd0, 32'sd0);
      send_poll(32'hFFFF_FFFF, 32'sh7FFF_FFFF);
      send_poll(32'd0, 32'sh8000_0000);
      send_poll(32'd5, 32'sh8000_0000);
      // manual drive in reverse
      wait_drained();
      write_reg(REG_MANUAL_DRIVE, 24'd255);
      write_reg(REG_MANUAL_REVERSE, 24'd1);
      write_reg(REG_CONTROL_MODE, 24'(MODE_MANUAL));
      send_poll(32'd10, 32'sd1);
      send_poll(32'd10, 32'sd1);
      // 192 changes at the same timestamp saturate the speed
      wait_drained();
      write_reg(REG_CONTROL_MODE, 24'(MODE_SPEED));
      write_reg(REG_TARGET_SPEED, 24'h800000);
      write_reg(REG_SAMPLE_PERIOD, 24'd0);
      m_t_now = 20;
      for (int i = 0; i < 192; i++) send_poll(m_t_now, m_last_pos + 1000);
      send_poll(m_t_now + 1, m_last_pos);
      send_poll(m_t_now + 5, m_last_pos);
      wait_drained();
      write_reg(REG_CONTROL_MODE, 24'(MODE_SPARE));
      send_poll(m_t_now + 6, m_last_pos);
      m_t_now += 6;
   endtask

   task automatic test_random_settings();
      for (int ph = 0; ph < 12; ph++) begin
         wait_drained();
         write_reg(REG_CONTROL_MODE,
                   ph % 4 == 3 ? 24'($urandom_range(0, 3)) : 24'(MODE_SPEED));
         write_reg(REG_TARGET_SPEED, ph == 0 ? 24'h7FFFFF : ($urandom_range(0, 1) ?
                   24'($urandom) : 24'($signed($urandom_range(0, 20000)) - 10000)));
         write_reg(REG_MANUAL_DRIVE, 24'($urandom_range(0, 255)));
         write_reg(REG_MANUAL_REVERSE, 24'($urandom_range(0, 1)));
         write_reg(REG_SAMPLE_PERIOD, ph == 1 ? 24'd65535 : 24'($urandom_range(1, 60)));
         write_reg(REG_GAIN_P, ph == 2 ? 24'd65535 :
                   (ph == 3 ? 24'd0 : 24'($urandom_range(0, 65535))));
         write_reg(REG_GAIN_I, ph == 2 ? 24'd65535 : 24'($urandom_range(0, 65535)));
         write_reg(REG_GAIN_D, ph == 2 ? 24'd65535 : 24'($urandom_range(0, 65535)));
         run_motion(88, ph % 2 ? 50 : 3, ph % 3 == 0 ? 80 : 4);
      end
   endtask

   // Hold off the receiver while requests keep coming
   task automatic test_backpressure();
      wait_drained();
      rx_hold = 1;
      hold_count = 300;
      run_motion(40, 5, 10);
      wait_drained();
   endtask

   task automatic test_flat_out();
      allow_idle = 0;
      run_motion(150, 4, 3);
      wait_drained();
   endtask

   // Receiver: random stalls, plus the long hold
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (rx_hold) begin
         rsp_ready <= 0;
         if (hold_count > 0) hold_count <= hold_count - 1;
         else rx_hold <= 0;
      end else if (!allow_idle) rsp_ready <= 1;
      else if (idle_cycles > 0) begin
         idle_cycles <= idle_cycles - 1;
         rsp_ready <= 0;
      end else if ($urandom_range(0, 7) == 0) begin
         idle_cycles <= $urandom_range(1, 15);
         rsp_ready <= 0;
      end else rsp_ready <= 1;
   end

   // Compare each result with the oldest prediction
   always @(posedge clock) begin
      drive_result_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_drive_level, rsp_reverse, rsp_brake, rsp_speed_updated,
                 rsp_measured_speed, rsp_is_stopped};
         if (expected_drive.size() == 0) begin
            $display("%0t: unexpected result %p", $realtime, got);
            failures++;
         end else begin
            want = expected_drive.pop_front();
            if (want.drive !== got.drive)
               $display("%0t: drive exp %0d got %0d", $realtime, want.drive, got.drive);
            if (want.rev !== got.rev)
               $display("%0t: reverse exp %0d got %0d", $realtime, want.rev, got.rev);
            if (want.brk !== got.brk)
               $display("%0t: brake exp %0d got %0d", $realtime, want.brk, got.brk);
            if (want.upd !== got.upd)
               $display("%0t: updated exp %0d got %0d", $realtime, want.upd, got.upd);
            if (want.speed !== got.speed)
               $display("%0t: speed exp %0d got %0d", $realtime, want.speed, got.speed);
            if (want.stopped !== got.stopped)
               $display("%0t: stopped exp %0d got %0d", $realtime, want.stopped,
                        got.stopped);
            if (want !== got) failures++;
         end
      end
   end

   // Watchdog on cycles with no handshake
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else quiet++;
         if (quiet > 5000) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset = 1;
      req_valid = 0; req_time_ms = 0; req_encoder_position = 0;
      csr_valid = 0; csr_index = 0; csr_wdata = 0;
      m_mode = MODE_BRAKE; m_target = 0; m_manual = 0; m_manual_rev = 0;
      m_period = 50; m_gp = 4588; m_gi = 1638; m_gd = 5243;
      m_last_pos = 0; m_mark_pos = 0; m_changes = 0; m_change_t = 0; m_mark_t = 0;
      m_pid_t = 0; m_t_now = 0; m_speed = 0; m_prev_err = 0; m_accum = 0; m_stall = 1;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random_settings();
      test_backpressure();
      test_flat_out();
      wait_drained();
      if (failures == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
